// ===== design/cbsp_pkg.sv =====
// ============================================================================
// cbsp_pkg
// Shared types, codes and helpers for the collision blob stream parser.
// ============================================================================
package cbsp_pkg;

    // Parse phase codes
    localparam logic [3:0] PH_HDR0 = 4'd0;
    localparam logic [3:0] PH_HDR1 = 4'd1;
    localparam logic [3:0] PH_CNTH = 4'd2;
    localparam logic [3:0] PH_CNTL = 4'd3;
    localparam logic [3:0] PH_VERT = 4'd4;
    localparam logic [3:0] PH_TERH = 4'd5;
    localparam logic [3:0] PH_TERL = 4'd6;
    localparam logic [3:0] PH_TCH  = 4'd7;
    localparam logic [3:0] PH_TCL  = 4'd8;
    localparam logic [3:0] PH_TRI  = 4'd9;
    localparam logic [3:0] PH_DONE = 4'd10;

    // Result kind codes
    localparam logic [2:0] KIND_VERTEX      = 3'd0;
    localparam logic [2:0] KIND_TRIANGLE    = 3'd1;
    localparam logic [2:0] KIND_END_OK      = 3'd2;
    localparam logic [2:0] KIND_BAD_HEADER  = 3'd3;
    localparam logic [2:0] KIND_BAD_TERRAIN = 3'd4;

    // Header and terrain constants
    localparam logic [7:0]  HEADER_LOW   = 8'h40;
    localparam logic [15:0] TERRAIN_END  = 16'h0041;
    localparam logic [15:0] TERRAIN_MAX  = 16'h00FF;

    // Byte positions inside a record
    localparam logic [2:0] POS_LAST_SIX   = 3'd5;
    localparam logic [2:0] POS_LAST_EIGHT = 3'd7;
    localparam logic [2:0] POS_BUF_LIMIT  = 3'd6;

    localparam logic [31:0] TRI_COUNT_MAX = 32'hFFFF_FFFF;

    // Parser state
    typedef struct packed {
        logic [3:0]  phase;
        logic [2:0]  byte_pos;
        logic [15:0] vert_left;
        logic [15:0] tri_left;
        logic        four_word;
        logic [7:0]  terrain;
        logic [47:0] rec_buf;
        logic [15:0] decl_vert;
        logic [31:0] tri_count;
    } state_t;

    // One result item
    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] coord_x;
        logic [15:0] coord_y;
        logic [15:0] coord_z;
        logic [15:0] index_a;
        logic [15:0] index_b;
        logic [15:0] index_c;
        logic [7:0]  surface_type;
        logic [15:0] vertex_total;
        logic [31:0] triangle_total;
    } result_t;

    // Terrain types whose entries carry a fourth halfword
    function automatic logic is_four_word(input logic [7:0] t);
        return (t == 8'h0E) || (t == 8'h2C) || (t == 8'h24) ||
               (t == 8'h25) || (t == 8'h27) || (t == 8'h2D);
    endfunction

endpackage

// ===== design/cbsp_step.sv =====
// ============================================================================
// cbsp_step
// Next-state and result logic for one blob byte.
// ============================================================================
module cbsp_step
    import cbsp_pkg::*;
(
    input  state_t      cur,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    output state_t      nxt,
    output logic        res_valid,
    output result_t     res
);

    state_t      eff;
    logic [47:0] shifted;
    logic [15:0] half;
    logic [15:0] vleft_dec;
    logic [15:0] tleft_dec;
    logic [2:0]  last_pos;

    // Restart discards progress
    always_comb
    begin
        eff = cur;
        if (first_byte)
        begin
            eff = '0;
            eff.phase = PH_HDR0;
        end
    end

    assign shifted   = {eff.rec_buf[39:0], data_byte};
    assign half      = {eff.rec_buf[7:0], data_byte};
    assign vleft_dec = eff.vert_left - 16'd1;
    assign tleft_dec = eff.tri_left - 16'd1;
    assign last_pos  = eff.four_word ? POS_LAST_EIGHT : POS_LAST_SIX;

    // Advance the parser by one byte
    always_comb
    begin
        nxt       = eff;
        res_valid = 1'b0;
        res       = '0;
        unique case (eff.phase)
            PH_HDR0:
            begin
                nxt.rec_buf = {40'd0, data_byte};
                nxt.phase   = PH_HDR1;
            end
            PH_HDR1:
            begin
                if ((eff.rec_buf != 48'd0) || (data_byte != HEADER_LOW))
                begin
                    res_valid          = 1'b1;
                    res.kind           = KIND_BAD_HEADER;
                    res.vertex_total   = eff.decl_vert;
                    res.triangle_total = eff.tri_count;
                    nxt.phase          = PH_DONE;
                end
                else
                begin
                    nxt.phase = PH_CNTH;
                end
            end
            PH_CNTH:
            begin
                nxt.rec_buf = {40'd0, data_byte};
                nxt.phase   = PH_CNTL;
            end
            PH_CNTL:
            begin
                nxt.decl_vert = half;
                nxt.vert_left = half;
                nxt.byte_pos  = 3'd0;
                nxt.phase     = (half != 16'd0) ? PH_VERT : PH_TERH;
            end
            PH_VERT:
            begin
                nxt.rec_buf = shifted;
                if (eff.byte_pos < POS_LAST_SIX)
                begin
                    nxt.byte_pos = eff.byte_pos + 3'd1;
                end
                else
                begin
                    nxt.byte_pos  = 3'd0;
                    nxt.vert_left = vleft_dec;
                    if (vleft_dec == 16'd0)
                    begin
                        nxt.phase = PH_TERH;
                    end
                    res_valid   = 1'b1;
                    res.kind    = KIND_VERTEX;
                    res.coord_x = shifted[47:32];
                    res.coord_y = shifted[31:16];
                    res.coord_z = shifted[15:0];
                end
            end
            PH_TERH:
            begin
                nxt.rec_buf = {40'd0, data_byte};
                nxt.phase   = PH_TERL;
            end
            PH_TERL:
            begin
                priority if (half == TERRAIN_END)
                begin
                    res_valid          = 1'b1;
                    res.kind           = KIND_END_OK;
                    res.vertex_total   = eff.decl_vert;
                    res.triangle_total = eff.tri_count;
                    nxt.phase          = PH_DONE;
                end
                else if (half > TERRAIN_MAX)
                begin
                    res_valid          = 1'b1;
                    res.kind           = KIND_BAD_TERRAIN;
                    res.vertex_total   = eff.decl_vert;
                    res.triangle_total = eff.tri_count;
                    nxt.phase          = PH_DONE;
                end
                else
                begin
                    nxt.terrain   = half[7:0];
                    nxt.four_word = is_four_word(half[7:0]);
                    nxt.phase     = PH_TCH;
                end
            end
            PH_TCH:
            begin
                nxt.rec_buf = {40'd0, data_byte};
                nxt.phase   = PH_TCL;
            end
            PH_TCL:
            begin
                nxt.tri_left = half;
                nxt.byte_pos = 3'd0;
                nxt.phase    = (half != 16'd0) ? PH_TRI : PH_TERH;
            end
            PH_TRI:
            begin
                if (eff.byte_pos < POS_BUF_LIMIT)
                begin
                    nxt.rec_buf = shifted;
                end
                if (eff.byte_pos == POS_LAST_SIX)
                begin
                    if (eff.tri_count != TRI_COUNT_MAX)
                    begin
                        nxt.tri_count = eff.tri_count + 32'd1;
                    end
                    res_valid        = 1'b1;
                    res.kind         = KIND_TRIANGLE;
                    res.index_a      = shifted[47:32];
                    res.index_b      = shifted[31:16];
                    res.index_c      = shifted[15:0];
                    res.surface_type = eff.terrain;
                end
                if (eff.byte_pos >= last_pos)
                begin
                    nxt.byte_pos = 3'd0;
                    nxt.tri_left = tleft_dec;
                    if (tleft_dec == 16'd0)
                    begin
                        nxt.phase = PH_TERH;
                    end
                end
                else
                begin
                    nxt.byte_pos = eff.byte_pos + 3'd1;
                end
            end
            default:
            begin
                // Done or unused code: ignore the byte
                nxt = eff;
            end
        endcase
    end

endmodule

// ===== design/collision_blob_stream_parser.sv =====
// ============================================================================
// collision_blob_stream_parser
// Parses a collision blob, one byte per item, into vertex, triangle and end
// items.
// ============================================================================
//
//  Channel   Dir  Payload                                        Accept
//  s_axis    in   tdata: data_byte; tuser: first_byte            tvalid & tready
//  m_axis    out  tdata: coords, indices, totals; tuser: kind    tvalid & tready
//
//  Each accepted byte updates the parser state and, when it completes a record,
//  loads a result at that edge into the output register, or the skid one if full.
//  A two-entry output stage (output register plus skid register) lets bytes
//  keep flowing while a result waits; s_axis_tready drops only when both are
//  full. Reset puts the parser in the header phase with all counters zero.
//
module collision_blob_stream_parser
    import cbsp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]   s_axis_tuser,   // [0] first_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [15:0] coord_x, [31:16] coord_y, [47:32] coord_z, [63:48] index_a,
    // [79:64] index_b, [95:80] index_c, [103:96] surface_type,
    // [119:104] vertex_total, [151:120] triangle_total
    output logic [151:0] m_axis_tdata,
    output logic [2:0]   m_axis_tuser    // [2:0] kind
);

    state_t  state_reg;
    state_t  state_next;
    logic    res_valid;
    result_t res;
    logic    in_acc;
    logic    push;
    logic    pop;

    logic    out_valid_reg;
    result_t out_reg;
    logic    skid_valid_reg;
    result_t skid_reg;

    // Per-byte parse logic
    cbsp_step u_step
    (
        .cur        (state_reg),
        .data_byte  (s_axis_tdata),
        .first_byte (s_axis_tuser[0]),
        .nxt        (state_next),
        .res_valid  (res_valid),
        .res        (res)
    );

    assign s_axis_tready = !skid_valid_reg;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign push          = in_acc && res_valid;
    assign pop           = out_valid_reg && m_axis_tready;

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{phase: PH_HDR0, default: '0};
        end
        else if (in_acc)
        begin
            state_reg <= state_next;
        end
    end

    // Output stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (pop && skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else if (pop && push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
            else if (push && out_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
            else if (push)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    // Output stage payload
    always_ff @(posedge clk)
    begin
        priority if (pop && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
        else if (pop && push)
        begin
            out_reg <= res;
        end
        else if (push && out_valid_reg)
        begin
            skid_reg <= res;
        end
        else if (push)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tdata  = {out_reg.triangle_total, out_reg.vertex_total,
                            out_reg.surface_type, out_reg.index_c, out_reg.index_b,
                            out_reg.index_a, out_reg.coord_z, out_reg.coord_y,
                            out_reg.coord_x};

    // Skid entry only ever holds an item behind a full output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register empty");

    // An end item leaves the parser in the done phase
    a_end_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (push && (res.kind == KIND_END_OK || res.kind == KIND_BAD_HEADER ||
                  res.kind == KIND_BAD_TERRAIN)) |=> (state_reg.phase == PH_DONE))
        else $error("end item without moving to done phase");

    // Done phase stays silent until a first byte arrives
    a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && state_reg.phase == PH_DONE && !s_axis_tuser[0]) |-> !res_valid)
        else $error("result produced after end of blob");

    // Phase never leaves the defined range
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase <= PH_DONE)
        else $error("parse phase out of range");

endmodule
